FILE: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, widths and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  // magnitude width of numerators and denominators
  localparam int MAG_BITS = 16;
  // working width: a sum of two 2*MAG_BITS products plus sign headroom
  localparam int DW       = 2 * MAG_BITS + 2;
  // counter width for the iterative units
  localparam int CW       = $clog2(DW + 1);

  typedef logic [MAG_BITS-1:0]   mag_t;
  typedef logic [2*MAG_BITS-1:0] prod_t;
  typedef logic [DW-1:0]         wide_t;
  typedef logic [CW-1:0]         cnt_t;

  // command codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic       a_neg;
    mag_t       a_num;
    mag_t       a_den;
    logic       b_neg;
    mag_t       b_num;
    mag_t       b_den;
  } in_item_t;

  typedef struct packed {
    logic       res_neg;
    mag_t       res_num;
    mag_t       res_den;
    logic       greater;
    logic       less;
    logic       equal;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_GCD1, S_DIVA, S_DIVB, S_MUL1, S_MUL2, S_MUL3,
    S_SUM, S_MULN, S_MULD, S_FIN, S_GCD2, S_DIVN, S_DIVD, S_OUT
  } state_t;

  // zero-extend a magnitude to the working width
  function automatic wide_t zx_mag(input mag_t v);
    return {{(DW - MAG_BITS){1'b0}}, v};
  endfunction

  // result item for compare and unused commands before flags are set
  function automatic out_item_t blank_out();
    out_item_t o;
    o         = '0;
    o.res_den = {{(MAG_BITS - 1){1'b0}}, 1'b1};
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: design/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Iterative binary GCD, one shift or subtract step per cycle. Both operands
// must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire rau_pkg::wide_t x_in,
  input  wire rau_pkg::wide_t y_in,
  output logic               done,
  output rau_pkg::wide_t     g
);

  rau_pkg::wide_t x_r, x_nxt;
  rau_pkg::wide_t y_r, y_nxt;
  rau_pkg::cnt_t  k_r, k_nxt;
  logic           run_r, run_nxt;
  logic           sh_r, sh_nxt;
  logic           done_r, done_nxt;

  // reduce phase, then shift back the common power of two
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    k_nxt    = k_r;
    run_nxt  = run_r;
    sh_nxt   = sh_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt   = x_in;
      y_nxt   = y_in;
      k_nxt   = '0;
      run_nxt = 1'b1;
      sh_nxt  = 1'b0;
    end else if (run_r && !sh_r) begin
      if (x_r == y_r) begin
        sh_nxt = 1'b1;
      end else if (!x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + rau_pkg::cnt_t'(1);
      end else if (!x_r[0]) begin
        x_nxt = x_r >> 1;
      end else if (!y_r[0]) begin
        y_nxt = y_r >> 1;
      end else if (x_r > y_r) begin
        x_nxt = x_r - y_r;
      end else begin
        y_nxt = y_r - x_r;
      end
    end else if (run_r) begin
      if (k_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        x_nxt = x_r << 1;
        k_nxt = k_r - rau_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      sh_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      sh_r   <= sh_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign g    = x_r;

endmodule

`default_nettype wire

FILE: design/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle. Divisor nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire rau_pkg::wide_t dividend,
  input  wire rau_pkg::wide_t divisor,
  output logic                done,
  output rau_pkg::wide_t      quotient
);

  rau_pkg::wide_t            rem_r, rem_nxt;
  rau_pkg::wide_t            quo_r, quo_nxt;
  rau_pkg::wide_t            dvs_r, dvs_nxt;
  rau_pkg::cnt_t             cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [rau_pkg::DW:0]      rem_sh;
  logic [rau_pkg::DW:0]      diff;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[rau_pkg::DW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = rau_pkg::CW'(rau_pkg::DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[rau_pkg::DW]) begin
        rem_nxt = diff[rau_pkg::DW-1:0];
        quo_nxt = {quo_r[rau_pkg::DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[rau_pkg::DW-1:0];
        quo_nxt = {quo_r[rau_pkg::DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - rau_pkg::cnt_t'(1);
      if (cnt_r == rau_pkg::CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: design/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Exact sign-magnitude rational add, subtract, multiply, divide and compare
// with GCD reduction and saturation, run by a sequencer over one GCD unit,
// one divider and one 16x16 multiplier.
// ----------------------------------------------------------------------------
//  channel | ports                           | direction | payload
//  input   | in_valid, in_stall, in_data     | in        | rau_pkg::in_item_t
//  result  | out_valid, out_stall, out_data  | out       | rau_pkg::out_item_t
//
//  One item at a time. Add/sub/compare: a GCD of the denominators, two
//  divides and three multiplies; every arithmetic result with nonzero
//  numerator and denominator then takes a GCD and two more divides. The
//  binary GCD unit takes one step per cycle.
//  Reset is synchronous, active low; no clearing pass. in_stall is high
//  while an item is at work; a finished item waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rau_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rau_pkg::out_item_t      out_data
);

  rau_pkg::state_t    state_r, state_nxt;
  rau_pkg::in_item_t  item_r, item_nxt;
  rau_pkg::out_item_t res_r, res_nxt;
  rau_pkg::out_item_t odata_r, odata_nxt;
  logic               ovalid_r, ovalid_nxt;
  rau_pkg::mag_t      sa_r, sa_nxt;
  rau_pkg::mag_t      sb_r, sb_nxt;
  rau_pkg::prod_t     ma_r, ma_nxt;
  rau_pkg::prod_t     mb_r, mb_nxt;
  rau_pkg::wide_t     num_r, num_nxt;
  rau_pkg::wide_t     den_r, den_nxt;
  logic               neg_r, neg_nxt;

  logic               gcd_start, gcd_done;
  rau_pkg::wide_t     gcd_x, gcd_y, gcd_g;
  logic               div_start, div_done;
  rau_pkg::wide_t     div_n, div_d, div_q;

  rau_pkg::mag_t      mul_a, mul_b;
  rau_pkg::prod_t     prod;
  rau_pkg::wide_t     sma, smb, rsum, rmag;
  logic               num_ovf, den_ovf;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x_in  (gcd_x),
    .y_in  (gcd_y),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // operand selection for the shared units
  always_comb begin
    gcd_x = rau_pkg::zx_mag(item_r.a_den);
    gcd_y = rau_pkg::zx_mag(item_r.b_den);
    if (state_r == rau_pkg::S_FIN) begin
      gcd_x = num_r;
      gcd_y = den_r;
    end
    div_d = gcd_g;
    unique case (state_r)
      rau_pkg::S_GCD1: div_n = rau_pkg::zx_mag(item_r.b_den);
      rau_pkg::S_DIVA: div_n = rau_pkg::zx_mag(item_r.a_den);
      rau_pkg::S_GCD2: div_n = num_r;
      default:         div_n = den_r;
    endcase
    unique case (state_r)
      rau_pkg::S_MUL1: begin mul_a = item_r.a_den; mul_b = sa_r;          end
      rau_pkg::S_MUL2: begin mul_a = item_r.a_num; mul_b = sa_r;          end
      rau_pkg::S_MUL3: begin mul_a = item_r.b_num; mul_b = sb_r;          end
      rau_pkg::S_MULN: begin
        mul_a = item_r.a_num;
        mul_b = (item_r.cmd == rau_pkg::CMD_DIV) ? item_r.b_den : item_r.b_num;
      end
      default: begin
        mul_a = item_r.a_den;
        mul_b = (item_r.cmd == rau_pkg::CMD_DIV) ? item_r.b_num : item_r.b_den;
      end
    endcase
    prod = rau_pkg::prod_t'(mul_a) * rau_pkg::prod_t'(mul_b);
  end

  // signed sum or difference of the scaled numerators
  always_comb begin
    sma  = item_r.a_neg ? (rau_pkg::wide_t'(0) - {2'b00, ma_r}) : {2'b00, ma_r};
    smb  = item_r.b_neg ? (rau_pkg::wide_t'(0) - {2'b00, mb_r}) : {2'b00, mb_r};
    rsum = (item_r.cmd == rau_pkg::CMD_ADD) ? (sma + smb) : (sma - smb);
    rmag = rsum[rau_pkg::DW-1] ? (rau_pkg::wide_t'(0) - rsum) : rsum;
    num_ovf = |num_r[rau_pkg::DW-1:rau_pkg::MAG_BITS];
    den_ovf = |den_r[rau_pkg::DW-1:rau_pkg::MAG_BITS];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    neg_nxt    = neg_r;
    gcd_start  = 1'b0;
    div_start  = 1'b0;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && out_stall;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = rau_pkg::S_DEC;
        end
      end
      rau_pkg::S_DEC: begin
        res_nxt = rau_pkg::blank_out();
        neg_nxt = item_r.a_neg ^ item_r.b_neg;
        case (item_r.cmd) inside
          rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_CMP: begin
            if (item_r.a_den == '0 || item_r.b_den == '0) begin
              // zero denominator: both scaled numerators and the LCM are zero
              ma_nxt    = '0;
              mb_nxt    = '0;
              den_nxt   = '0;
              state_nxt = rau_pkg::S_SUM;
            end else begin
              gcd_start = 1'b1;
              state_nxt = rau_pkg::S_GCD1;
            end
          end
          rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: state_nxt = rau_pkg::S_MULN;
          default:                            state_nxt = rau_pkg::S_OUT;
        endcase
      end
      rau_pkg::S_GCD1: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIVA;
        end
      end
      rau_pkg::S_DIVA: begin
        if (div_done) begin
          sa_nxt    = div_q[rau_pkg::MAG_BITS-1:0];
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIVB;
        end
      end
      rau_pkg::S_DIVB: begin
        if (div_done) begin
          sb_nxt    = div_q[rau_pkg::MAG_BITS-1:0];
          state_nxt = rau_pkg::S_MUL1;
        end
      end
      rau_pkg::S_MUL1: begin
        den_nxt   = {2'b00, prod};
        state_nxt = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        ma_nxt    = prod;
        state_nxt = rau_pkg::S_MUL3;
      end
      rau_pkg::S_MUL3: begin
        mb_nxt    = prod;
        state_nxt = rau_pkg::S_SUM;
      end
      rau_pkg::S_SUM: begin
        if (item_r.cmd == rau_pkg::CMD_CMP) begin
          res_nxt.less    = rsum[rau_pkg::DW-1];
          res_nxt.equal   = (rsum == '0);
          res_nxt.greater = !rsum[rau_pkg::DW-1] && (rsum != '0);
          state_nxt       = rau_pkg::S_OUT;
        end else begin
          num_nxt   = rmag;
          neg_nxt   = rsum[rau_pkg::DW-1];
          state_nxt = rau_pkg::S_FIN;
        end
      end
      rau_pkg::S_MULN: begin
        num_nxt   = {2'b00, prod};
        state_nxt = rau_pkg::S_MULD;
      end
      rau_pkg::S_MULD: begin
        den_nxt   = {2'b00, prod};
        state_nxt = rau_pkg::S_FIN;
      end
      rau_pkg::S_FIN: begin
        res_nxt.res_neg = neg_r;
        if (den_r == '0) begin
          res_nxt.res_num = rau_pkg::mag_t'(1);
          res_nxt.res_den = rau_pkg::mag_t'(1);
          res_nxt.status  = rau_pkg::ST_ZDEN;
          state_nxt       = rau_pkg::S_OUT;
        end else if (num_r == '0) begin
          // zero numerator is left unreduced
          state_nxt = rau_pkg::S_DIVD;
        end else begin
          gcd_start = 1'b1;
          state_nxt = rau_pkg::S_GCD2;
        end
      end
      rau_pkg::S_GCD2: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIVN;
        end
      end
      rau_pkg::S_DIVN: begin
        if (div_done) begin
          num_nxt   = div_q;
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIVD;
        end
      end
      rau_pkg::S_DIVD: begin
        // wait for the denominator quotient unless reduction was skipped
        if (div_done || num_r == '0) begin
          if (div_done) begin
            den_nxt = div_q;
          end
          state_nxt = rau_pkg::S_OUT;
        end
      end
      rau_pkg::S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          odata_nxt  = res_r;
          ovalid_nxt = 1'b1;
          state_nxt  = rau_pkg::S_IDLE;
        end
      end
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
    // saturate the reduced magnitudes on the way out of the divide stage
    if (state_r == rau_pkg::S_DIVD && (div_done || num_r == '0)) begin
      if (div_done) begin
        res_nxt.res_den = (|div_q[rau_pkg::DW-1:rau_pkg::MAG_BITS]) ? '1 :
                          div_q[rau_pkg::MAG_BITS-1:0];
      end else begin
        res_nxt.res_den = den_ovf ? '1 : den_r[rau_pkg::MAG_BITS-1:0];
      end
      res_nxt.res_num = num_ovf ? '1 : num_r[rau_pkg::MAG_BITS-1:0];
      res_nxt.status  = (num_ovf || (div_done ?
                         (|div_q[rau_pkg::DW-1:rau_pkg::MAG_BITS]) : den_ovf)) ?
                        rau_pkg::ST_OVF : rau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    neg_r   <= neg_nxt;
    if (!rst_n) begin
      state_r  <= rau_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != rau_pkg::S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // a new result is only loaded from the output state
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == rau_pkg::S_OUT))
    else $error("result loaded outside output state");

  // GCD completions only arrive while the sequencer waits for them
  a_gcd_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> (state_r == rau_pkg::S_GCD1 || state_r == rau_pkg::S_GCD2))
    else $error("unexpected GCD completion");

  // divider completions only arrive while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == rau_pkg::S_DIVA || state_r == rau_pkg::S_DIVB ||
                  state_r == rau_pkg::S_DIVN || state_r == rau_pkg::S_DIVD))
    else $error("unexpected divider completion");

  // compare flags are exclusive and never come with a nonzero status
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> ($onehot0({odata_r.greater, odata_r.less, odata_r.equal}) &&
                  (!(odata_r.greater || odata_r.less || odata_r.equal) ||
                   odata_r.status == rau_pkg::ST_OK)))
    else $error("bad result flags");

endmodule

`default_nettype wire
